FILE: rtl/gauss_seidel_linear_solver_core_macros.svh
// Assertion macros for the Gauss-Seidel solver core.
// No dependencies; included by files that assert.
`ifndef GAUSS_SEIDEL_LINEAR_SOLVER_CORE_MACROS_SVH
`define GAUSS_SEIDEL_LINEAR_SOLVER_CORE_MACROS_SVH
// implication checked every clock, off in reset
`define GS_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define GS_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

FILE: rtl/gs_pkg.sv
// Package for the Gauss-Seidel solver core: function codes, config indices, states, fixed-point widths.
// No dependencies.
`default_nettype none
package gs_pkg;
	typedef enum logic [1:0] {
		FUNC_LOAD_A   = 2'd0,
		FUNC_LOAD_B   = 2'd1,
		FUNC_LOAD_X   = 2'd2,
		FUNC_START    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		CFG_MATRIX_SIZE = 2'd0,
		CFG_SWEEP_COUNT = 2'd1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROW,     // issue reads for b[i], A[i][i]
		ST_ROWW,    // capture b, diag
		ST_TERM,    // issue A[i][j], x[j]
		ST_MUL,     // multiply
		ST_SUB,     // saturating subtract
		ST_DIV,     // divider running
		ST_WB,      // write x[i]
		ST_ORD,     // issue output read
		ST_OUT      // hold result
	} state_t;

	localparam int INT_BITS = 8;
	// unknowns; tied to the 4-bit row, col and x_index ports
	localparam int MAX_UNKNOWNS = 16;
endpackage
`default_nettype wire

FILE: rtl/gs_div.sv
// Iterative signed fixed-point divider, one quotient bit per cycle, saturating.
// Depends on gs_pkg.
`default_nettype none
module gs_div #(
	parameter int W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] num,
	input  wire logic [W-1:0] den,
	output logic              done,
	output logic [W-1:0]      quo
);
	import gs_pkg::*;
	localparam int F = W - INT_BITS;
	localparam int NB = W + F;
	localparam int CW = $clog2(NB + 1);

	logic [NB-1:0] dvd_q;
	logic [W-1:0]  rem_q;
	logic [NB-1:0] q_q;
	logic [W-1:0]  d_q;
	logic          neg_q, busy_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  mn, md;
	logic [W:0]    trial;
	logic [W:0]    rdiff;
	logic [W-1:0]  lim;

	assign mn = num[W-1] ? (~num + 1'b1) : num;
	assign md = den[W-1] ? (~den + 1'b1) : den;
	assign trial = {rem_q, dvd_q[NB-1]};
	assign rdiff = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// remainder stays below the divisor, so it fits in W bits
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {mn, {F{1'b0}}};
			rem_q <= '0;
			q_q   <= '0;
			d_q   <= md;
			neg_q <= num[W-1] ^ den[W-1];
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (trial >= {1'b0, d_q}) begin
				rem_q <= rdiff[W-1:0];
				q_q   <= {q_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= trial[W-1:0];
				q_q   <= {q_q[NB-2:0], 1'b0};
			end
		end
	end

	// saturate and sign
	always_comb begin
		lim = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		if (q_q[NB-1:W-1] != '0 && !(neg_q && q_q[NB-1:W-1] == {{(NB-W){1'b0}}, 1'b1}
				&& q_q[W-2:0] == '0))
			quo = lim;
		else if (neg_q)
			quo = ~q_q[W-1:0] + 1'b1;
		else
			quo = q_q[W-1:0];
	end
endmodule
`default_nettype wire

FILE: rtl/gauss_seidel_linear_solver_core.sv
// Gauss-Seidel solver core: top level, stores, sweep sequencer, result stream.
// Depends on gs_pkg, gs_div and gauss_seidel_linear_solver_core_macros.svh.
//
// Load requests (matrix, rhs, guess) are taken one per cycle and written straight into
// synchronous memories. A start request runs sweep_count sweeps; each unknown steps
// through row setup (ST_ROW, ST_ROWW), a read, multiply and saturating subtract per
// off-diagonal term (ST_TERM, ST_MUL, ST_SUB), the bit-serial divider (ST_DIV) and a
// write-back (ST_WB); solve time is set by the single shared multiplier and the divider.
// Results then stream out as n results, each read in ST_ORD and held in ST_OUT until taken.
// No load or start is taken while a solve runs. Stores are undefined until written.
`default_nettype none
module gauss_seidel_linear_solver_core #(
	parameter int VALUE_WIDTH  = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [1:0]             func,
	input  wire logic [3:0]             row,
	input  wire logic [3:0]             col,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [3:0]                  x_index,
	output logic signed [VALUE_WIDTH-1:0] x_value,
	output logic                        last,
	output logic                        zero_pivot,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [15:0]            cfg_data
);
	import gs_pkg::*;
	`include "gauss_seidel_linear_solver_core_macros.svh"

	localparam int W  = VALUE_WIDTH;
	localparam int F  = W - INT_BITS;
	localparam int IW = $clog2(MAX_UNKNOWNS);
	localparam int NW = IW + 1;
	localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

	// memories
	logic [W-1:0] a_mem [MAX_UNKNOWNS*MAX_UNKNOWNS];
	logic [W-1:0] b_mem [MAX_UNKNOWNS];
	logic [W-1:0] x_mem [MAX_UNKNOWNS];
	logic [W-1:0] a_rd, b_rd, x_rd;
	logic [2*IW-1:0] a_ra;
	logic [IW-1:0]   b_ra, x_ra;

	state_t st_q, st_d;
	logic [4:0]   size_q;
	logic [15:0]  sweeps_q, sw_q;
	logic [NW-1:0] n_q;
	logic [IW-1:0] i_q, j_q;
	logic [W-1:0] acc_q, diag_q;
	logic signed [2*W-1:0] prod_s1;
	logic         zp_q;
	logic         div_start, div_done;
	logic [W-1:0] quo;
	logic         in_fire, ld_ok;

	assign cfg_ready = (st_q == ST_IDLE);
	assign in_ready  = (st_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign ld_ok = (NW'(row) < NW'(MAX_UNKNOWNS)) && (NW'(col) < NW'(MAX_UNKNOWNS));

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (in_fire && func == FUNC_START) st_d = (sweeps_q == 0) ? ST_ORD : ST_ROW;
			ST_ROW:  st_d = ST_ROWW;
			ST_ROWW: st_d = (n_q == NW'(1)) ? ST_DIV : ST_TERM;
			ST_TERM: st_d = ST_MUL;
			ST_MUL:  st_d = ST_SUB;
			ST_SUB:  st_d = (NW'(j_q) + 1'b1 == n_q ||
					(NW'(j_q) + 2'd2 == n_q && j_q + 1'b1 == i_q)) ? ST_DIV : ST_TERM;
			ST_DIV:  if (div_done || diag_q == '0) st_d = ST_WB;
			ST_WB:   if (NW'(i_q) + 1'b1 == n_q && sw_q == 16'd1) st_d = ST_ORD;
				else st_d = ST_ROW;
			ST_ORD:  st_d = ST_OUT;
			ST_OUT:  if (out_ready) st_d = (NW'(i_q) + 1'b1 == n_q) ? ST_IDLE : ST_ORD;
			default: st_d = ST_IDLE;
		endcase
	end

	// read addresses
	logic [IW-1:0] jn;
	always_comb begin
		jn = (j_q == i_q) ? j_q + 1'b1 : j_q;
		a_ra = {i_q, i_q};
		b_ra = i_q;
		x_ra = i_q;
		if (st_q == ST_TERM) begin
			a_ra = {i_q, jn};
			x_ra = jn;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && ld_ok) begin
			case (func)
				FUNC_LOAD_A: a_mem[{row[IW-1:0], col[IW-1:0]}] <= value;
				FUNC_LOAD_B: b_mem[row[IW-1:0]] <= value;
				FUNC_LOAD_X: x_mem[row[IW-1:0]] <= value;
				default: ;
			endcase
		end
		if (st_q == ST_WB && diag_q != '0) x_mem[i_q] <= quo;
		a_rd <= a_mem[a_ra];
		b_rd <= b_mem[b_ra];
		x_rd <= x_mem[x_ra];
	end

	// multiply, truncate toward zero, saturate, then saturating subtract from the accumulator
	logic [2*W-1:0] pm;
	logic           pneg;
	logic [W-1:0]   term, diff;
	logic [2*W-1:0] tmag;
	always_comb begin
		pneg = prod_s1[2*W-1];
		pm   = pneg ? (~prod_s1 + 1'b1) : prod_s1;
		tmag = pm >> F;
		if (tmag[2*W-1:W-1] != '0 && !(pneg && tmag[2*W-1:W-1] == {{W{1'b0}}, 1'b1}
				&& tmag[W-2:0] == '0))
			term = pneg ? VMIN : VMAX;
		else
			term = pneg ? ~tmag[W-1:0] + 1'b1 : tmag[W-1:0];
		diff = acc_q - term;
		if (acc_q[W-1] != term[W-1] && diff[W-1] != acc_q[W-1])
			diff = acc_q[W-1] ? VMIN : VMAX;
	end

	assign div_start = (st_d == ST_DIV) && (st_q != ST_DIV);

	// a single-unknown row starts the divider straight from the read data
	gs_div #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num((st_q == ST_SUB) ? diff : (st_q == ST_ROWW) ? b_rd : acc_q),
		.den((st_q == ST_ROWW) ? a_rd : diag_q),
		.done(div_done), .quo(quo)
	);

	always_ff @(posedge clk) begin
		if (st_q == ST_TERM || st_q == ST_MUL)
			prod_s1 <= $signed(a_rd) * $signed(x_rd);
		if (st_q == ST_ROWW) begin
			acc_q  <= b_rd;
			diag_q <= a_rd;
		end
		if (st_q == ST_SUB) acc_q <= diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			size_q   <= 5'd16;
			sweeps_q <= 16'd1;
			sw_q     <= '0;
			n_q      <= '0;
			i_q      <= '0;
			j_q      <= '0;
			zp_q     <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MATRIX_SIZE) size_q <= cfg_data[4:0];
				else if (cfg_index == CFG_SWEEP_COUNT) sweeps_q <= cfg_data;
			end
			case (st_q)
				ST_IDLE: if (in_fire && func == FUNC_START) begin
					sw_q <= sweeps_q;
					zp_q <= 1'b0;
					i_q  <= '0;
					if (size_q == 0) n_q <= NW'(1);
					else if (6'(size_q) > 6'(MAX_UNKNOWNS)) n_q <= NW'(MAX_UNKNOWNS);
					else n_q <= NW'(size_q);
				end
				ST_ROWW: j_q <= (i_q == '0) ? IW'(1) : '0;
				ST_SUB:  j_q <= (jn + 1'b1 == i_q) ? jn + 2'd2 : jn + 1'b1;
				ST_DIV:  if (diag_q == '0) zp_q <= 1'b1;
				ST_WB: begin
					if (NW'(i_q) + 1'b1 == n_q) begin
						i_q  <= '0;
						sw_q <= sw_q - 1'b1;
					end else i_q <= i_q + 1'b1;
				end
				ST_OUT: if (out_ready) i_q <= i_q + 1'b1;
				default: ;
			endcase
		end
	end

	// outputs
	always_comb begin
		out_valid  = (st_q == ST_OUT);
		x_index    = 4'(i_q);
		x_value    = x_rd;
		last       = (NW'(i_q) + 1'b1 == n_q);
		zero_pivot = zp_q;
	end

	`GS_ASSERT_IMP(a_busy_no_req, clk, arst_n, st_q != ST_IDLE, !in_ready && !cfg_ready,
		"request taken while solving")
	`GS_ASSERT_IMP(a_idx_rng, clk, arst_n, out_valid, NW'(i_q) < n_q, "index past size")
	`GS_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(x_index),
		"result dropped")
endmodule
`default_nettype wire
